>>> rtl/msog_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the matrix scan order generator
// no dependencies; used by matrix_scan_order_generator and its testbench

package msog_pkg;

    // largest matrix side; the largest half side follows from it
    localparam int MAX_SIDE = 32;
    localparam int MAX_HALF = MAX_SIDE / 2;

    // field widths
    localparam int POS_W  = 5;
    localparam int SEQ_W  = 10;
    localparam int MODE_W = 2;
    localparam int HALF_W = 5;
    localparam int DIAG_W = 6;
    localparam int CFG_W  = 5;
    localparam int IDX_W  = 1;

    // scan order codes
    localparam logic [MODE_W-1:0] MODE_DIAG     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ANTI     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SPIRAL_I = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPIRAL_O = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_SCAN_MODE = 1'b0;
    localparam logic [IDX_W-1:0] CFG_HALF_SIDE = 1'b1;

    localparam logic [HALF_W-1:0] HALF_RESET = 5'd10;

    // spiral leg, one-hot
    typedef enum logic [3:0] {
        LEG_A = 4'b0001,
        LEG_B = 4'b0010,
        LEG_C = 4'b0100,
        LEG_D = 4'b1000
    } t_leg;

endpackage

>>> rtl/matrix_scan_order_generator.sv
`timescale 1ns / 1ps
// matrix scan order generator: walks an N by N matrix in one of four orders
// depends on msog_pkg
//
// Usage: each beat accepted on the input channel (i_in_valid / o_in_ready)
// yields exactly one address beat on the output channel (o_out_valid /
// i_out_ready) carrying row, column, position in the order and a flag on
// the final cell. i_restart high sends the order back to its first cell.
// Order and half side are written on the plain write port (i_cfg_we,
// i_cfg_idx, i_cfg_data) while the block is idle; any write makes the next
// beat start the order afresh.
// The address of a beat accepted at one edge is shown from that edge on.
// Throughput is one beat per cycle while the receiver keeps up: the walk
// state and the output register are both updated in the cycle of
// acceptance, and a new beat is taken whenever the output register is
// empty or is being emptied in the same cycle.
// When the receiver stalls, the pending address holds and o_in_ready
// drops until it is taken. Synchronous reset clears the walk, empties the
// output register and loads diagonal order with a half side of ten.

module matrix_scan_order_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [msog_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [msog_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_restart,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [msog_pkg::POS_W-1:0]      o_row,
    output logic [msog_pkg::POS_W-1:0]      o_col,
    output logic [msog_pkg::SEQ_W-1:0]      o_seq_index,
    output logic                            o_last
);

    localparam int W6 = msog_pkg::POS_W + 1;

    // configuration
    logic [msog_pkg::MODE_W-1:0] r_mode;
    logic [msog_pkg::HALF_W-1:0] r_half;

    // walk state
    msog_pkg::t_leg              r_leg, n_leg;
    logic [msog_pkg::POS_W-1:0]  r_ring, n_ring;
    logic [msog_pkg::POS_W-1:0]  r_cur_row, n_cur_row;
    logic [msog_pkg::POS_W-1:0]  r_cur_col, n_cur_col;
    logic [msog_pkg::DIAG_W-1:0] r_diag, n_diag;
    logic [msog_pkg::SEQ_W-1:0]  r_count, n_count;
    logic                        r_started;

    // output register
    logic                        r_out_valid;
    logic [msog_pkg::POS_W-1:0]  r_row, r_col;
    logic [msog_pkg::SEQ_W-1:0]  r_seq;
    logic                        r_last;

    logic                        in_acc;
    logic                        first;
    logic [msog_pkg::POS_W-1:0]  eff_h;
    logic [W6-1:0]               h6, side6, sidem1;
    logic [2*msog_pkg::POS_W-1:0] h_sq, h_sq_m1;
    logic [msog_pkg::SEQ_W-1:0]  total_m1;
    logic [W6-1:0]               row6, col6, ring6;
    logic [W6-1:0]               lo2, hi2, lo3, hi3;
    logic [msog_pkg::DIAG_W-1:0] diag_k;
    logic [W6-1:0]               dk_row, dk_col;
    logic [W6-1:0]               w_row, w_col;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    // effective half side: zero acts as one, large values saturate
    always_comb begin
        if (r_half == '0) begin
            eff_h = msog_pkg::POS_W'(1);
        end else if (r_half > msog_pkg::HALF_W'(msog_pkg::MAX_HALF)) begin
            eff_h = msog_pkg::POS_W'(msog_pkg::MAX_HALF);
        end else begin
            eff_h = r_half;
        end
    end

    assign h6       = {1'b0, eff_h};
    assign side6    = {eff_h, 1'b0};
    assign sidem1   = side6 - W6'(1);
    assign h_sq     = eff_h * eff_h;
    assign h_sq_m1  = h_sq - (2*msog_pkg::POS_W)'(1);
    // 4*h*h - 1
    assign total_m1 = {h_sq_m1[msog_pkg::SEQ_W-3:0], 2'b11};

    assign row6  = {1'b0, r_cur_row};
    assign col6  = {1'b0, r_cur_col};
    assign ring6 = {1'b0, r_ring};
    assign lo2   = ring6;
    assign hi2   = sidem1 - ring6;
    assign lo3   = h6 - W6'(1) - ring6;
    assign hi3   = h6 + ring6;

    assign first = i_restart || !r_started || (r_count >= total_m1);

    // first cell of the next diagonal
    assign diag_k = r_diag + msog_pkg::DIAG_W'(1);
    always_comb begin
        if (r_mode == msog_pkg::MODE_DIAG) begin
            if (W6'(diag_k) <= sidem1) begin
                dk_row = '0;
                dk_col = sidem1 - W6'(diag_k);
            end else begin
                dk_row = W6'(diag_k) - sidem1;
                dk_col = '0;
            end
        end else begin
            dk_row = (W6'(diag_k) < sidem1) ? W6'(diag_k) : sidem1;
            dk_col = W6'(diag_k) - dk_row;
        end
    end

    always_comb begin
        n_leg   = r_leg;
        n_ring  = r_ring;
        n_diag  = r_diag;
        n_count = r_count + msog_pkg::SEQ_W'(1);
        w_row   = row6;
        w_col   = col6;
        if (first) begin
            n_leg   = msog_pkg::LEG_A;
            n_ring  = '0;
            n_diag  = '0;
            n_count = '0;
            w_row   = '0;
            w_col   = '0;
            case (r_mode)
                msog_pkg::MODE_DIAG: begin
                    w_col = sidem1;
                end
                msog_pkg::MODE_SPIRAL_O: begin
                    // innermost ring has no left column leg
                    n_leg = msog_pkg::LEG_B;
                    w_row = h6;
                    w_col = h6 - W6'(1);
                end
                default: begin
                end
            endcase
        end else begin
            case (r_mode)
                msog_pkg::MODE_DIAG: begin
                    if (row6 + W6'(1) < side6 && col6 + W6'(1) < side6) begin
                        w_row = row6 + W6'(1);
                        w_col = col6 + W6'(1);
                    end else begin
                        n_diag = diag_k;
                        w_row  = dk_row;
                        w_col  = dk_col;
                    end
                end
                msog_pkg::MODE_ANTI: begin
                    if (row6 != '0 && col6 + W6'(1) < side6) begin
                        w_row = row6 - W6'(1);
                        w_col = col6 + W6'(1);
                    end else begin
                        n_diag = diag_k;
                        w_row  = dk_row;
                        w_col  = dk_col;
                    end
                end
                msog_pkg::MODE_SPIRAL_I: begin
                    case (r_leg)
                        msog_pkg::LEG_A: begin
                            if (col6 < hi2) begin
                                w_col = col6 + W6'(1);
                            end else if (hi2 >= lo2 + W6'(2)) begin
                                n_leg = msog_pkg::LEG_B;
                                w_row = lo2 + W6'(1);
                                w_col = hi2;
                            end else begin
                                n_leg = msog_pkg::LEG_C;
                                w_row = hi2;
                                w_col = hi2;
                            end
                        end
                        msog_pkg::LEG_B: begin
                            if (row6 + W6'(1) < hi2) begin
                                w_row = row6 + W6'(1);
                            end else begin
                                n_leg = msog_pkg::LEG_C;
                                w_row = hi2;
                                w_col = hi2;
                            end
                        end
                        msog_pkg::LEG_C: begin
                            if (col6 > lo2) begin
                                w_col = col6 - W6'(1);
                            end else if (hi2 >= lo2 + W6'(2)) begin
                                n_leg = msog_pkg::LEG_D;
                                w_row = hi2 - W6'(1);
                                w_col = lo2;
                            end else begin
                                n_leg  = msog_pkg::LEG_A;
                                n_ring = r_ring + msog_pkg::POS_W'(1);
                                w_row  = lo2 + W6'(1);
                                w_col  = lo2 + W6'(1);
                            end
                        end
                        default: begin
                            if (row6 > lo2 + W6'(1)) begin
                                w_row = row6 - W6'(1);
                            end else begin
                                n_leg  = msog_pkg::LEG_A;
                                n_ring = r_ring + msog_pkg::POS_W'(1);
                                w_row  = lo2 + W6'(1);
                                w_col  = lo2 + W6'(1);
                            end
                        end
                    endcase
                end
                default: begin
                    case (r_leg)
                        msog_pkg::LEG_A: begin
                            if (row6 + W6'(1) < hi3) begin
                                w_row = row6 + W6'(1);
                            end else begin
                                n_leg = msog_pkg::LEG_B;
                                w_row = hi3;
                                w_col = lo3;
                            end
                        end
                        msog_pkg::LEG_B: begin
                            if (col6 < hi3) begin
                                w_col = col6 + W6'(1);
                            end else if (hi3 >= lo3 + W6'(2)) begin
                                n_leg = msog_pkg::LEG_C;
                                w_row = hi3 - W6'(1);
                                w_col = hi3;
                            end else begin
                                n_leg = msog_pkg::LEG_D;
                                w_row = lo3;
                                w_col = hi3;
                            end
                        end
                        msog_pkg::LEG_C: begin
                            if (row6 > lo3 + W6'(1)) begin
                                w_row = row6 - W6'(1);
                            end else begin
                                n_leg = msog_pkg::LEG_D;
                                w_row = lo3;
                                w_col = hi3;
                            end
                        end
                        default: begin
                            if (col6 > lo3) begin
                                w_col = col6 - W6'(1);
                            end else begin
                                // next ring out starts one below its top-left corner
                                n_leg  = msog_pkg::LEG_A;
                                n_ring = r_ring + msog_pkg::POS_W'(1);
                                w_row  = lo3;
                                w_col  = lo3 - W6'(1);
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    assign n_cur_row = w_row[msog_pkg::POS_W-1:0];
    assign n_cur_col = w_col[msog_pkg::POS_W-1:0];

    // configuration and walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= msog_pkg::MODE_DIAG;
            r_half    <= msog_pkg::HALF_RESET;
            r_leg     <= msog_pkg::LEG_A;
            r_ring    <= '0;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_diag    <= '0;
            r_count   <= '0;
            r_started <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                msog_pkg::CFG_SCAN_MODE: r_mode <= i_cfg_data[msog_pkg::MODE_W-1:0];
                msog_pkg::CFG_HALF_SIDE: r_half <= i_cfg_data[msog_pkg::HALF_W-1:0];
                default: begin
                end
            endcase
            r_started <= 1'b0;
        end else if (in_acc) begin
            r_leg     <= n_leg;
            r_ring    <= n_ring;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_diag    <= n_diag;
            r_count   <= n_count;
            r_started <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row  <= n_cur_row;
            r_col  <= n_cur_col;
            r_seq  <= n_count;
            r_last <= (n_count == total_m1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_row       = r_row;
    assign o_col       = r_col;
    assign o_seq_index = r_seq;
    assign o_last      = r_last;

    // a restart beat always comes out as the first cell
    a_restart_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_restart |=> r_out_valid && r_seq == '0)
        else $error("restart beat did not give position zero");

    // an ordinary step moves one place along the order
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_cfg_we && !i_restart && r_started && r_count < total_m1
        |=> r_count == $past(r_count) + msog_pkg::SEQ_W'(1))
        else $error("position did not advance by one");

    // the final cell carries the last position of the order
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_last |-> r_seq == total_m1)
        else $error("last flag on a wrong position");

    // addresses stay inside the matrix
    a_in_matrix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_started |-> {1'b0, r_row} < side6 && {1'b0, r_col} < side6)
        else $error("address outside the matrix");

endmodule

>>> sim/matrix_scan_order_generator_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the matrix scan order generator
// depends on msog_pkg and matrix_scan_order_generator
// a table of directed writes and beats, then random phases

module matrix_scan_order_generator_tb;

    localparam int RANDOM_BEATS = 1450;
    localparam int PLAN_LEN     = 31;

    typedef struct packed {
        logic [msog_pkg::POS_W-1:0] row;
        logic [msog_pkg::POS_W-1:0] col;
        logic [msog_pkg::SEQ_W-1:0] seq;
        logic                       is_last;
    } t_scan_addr;

    // one table row: either a register write or a beat, optionally with a typed address
    typedef struct packed {
        logic                       is_cfg;
        logic [msog_pkg::IDX_W-1:0] idx;
        logic [msog_pkg::CFG_W-1:0] data;
        logic                       restart;
        logic                       typed;
        t_scan_addr                 addr;
    } t_plan_row;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_we    = 1'b0;
    logic [msog_pkg::IDX_W-1:0]   i_cfg_idx   = '0;
    logic [msog_pkg::CFG_W-1:0]   i_cfg_data  = '0;
    logic                         i_in_valid  = 1'b0;
    logic                         i_restart   = 1'b0;
    logic                         i_out_ready = 1'b0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic [msog_pkg::POS_W-1:0]   o_row;
    logic [msog_pkg::POS_W-1:0]   o_col;
    logic [msog_pkg::SEQ_W-1:0]   o_seq_index;
    logic                         o_last;

    // predictor copy of registers and walk state
    logic [msog_pkg::MODE_W-1:0]  cfg_mode   = msog_pkg::MODE_DIAG;
    logic [msog_pkg::HALF_W-1:0]  cfg_half   = msog_pkg::HALF_RESET;
    msog_pkg::t_leg               walk_leg   = msog_pkg::LEG_A;
    int                           walk_ring  = 0;
    int                           walk_row   = 0;
    int                           walk_col   = 0;
    int                           walk_diag  = 0;
    int                           walk_pos   = 0;
    logic                         walk_live  = 1'b0;

    t_scan_addr         addresses_due[$];
    int                 mismatches = 0;
    int                 idle_phase = 0;

    matrix_scan_order_generator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_row       (o_row),
        .o_col       (o_col),
        .o_seq_index (o_seq_index),
        .o_last      (o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic int effective_half();
        int h;
        h = int'(cfg_half);
        if (h == 0) h = 1;
        if (h > msog_pkg::MAX_HALF) h = msog_pkg::MAX_HALF;
        return h;
    endfunction

    // first cell of diagonal number walk_diag
    function automatic void load_diagonal(int side);
        int k;
        int r;
        k = walk_diag;
        if (cfg_mode == msog_pkg::MODE_DIAG) begin
            if (k <= side - 1) begin
                walk_row = 0;
                walk_col = side - 1 - k;
            end else begin
                walk_row = k - (side - 1);
                walk_col = 0;
            end
        end else begin
            r = (k < side - 1) ? k : side - 1;
            walk_row = r;
            walk_col = k - r;
        end
    endfunction

    // first cell of ring walk_ring; the innermost outward ring has no column legs
    function automatic void load_ring(int h);
        int lo;
        int hi;
        if (cfg_mode == msog_pkg::MODE_SPIRAL_I) begin
            walk_row = walk_ring;
            walk_col = walk_ring;
            walk_leg = msog_pkg::LEG_A;
        end else begin
            lo = h - 1 - walk_ring;
            hi = h + walk_ring;
            walk_col = lo;
            if (hi - lo >= 2) begin
                walk_leg = msog_pkg::LEG_A;
                walk_row = lo + 1;
            end else begin
                walk_leg = msog_pkg::LEG_B;
                walk_row = hi;
            end
        end
    endfunction

    function automatic void rewind_walk(int h);
        walk_leg  = msog_pkg::LEG_A;
        walk_ring = 0;
        walk_diag = 0;
        walk_pos  = 0;
        if (cfg_mode == msog_pkg::MODE_DIAG || cfg_mode == msog_pkg::MODE_ANTI) begin
            load_diagonal(2 * h);
        end else begin
            load_ring(h);
        end
    endfunction

    function automatic void advance_walk(int h);
        int side;
        int lo;
        int hi;
        side = 2 * h;
        case (cfg_mode)
            msog_pkg::MODE_DIAG: begin
                if (walk_row + 1 < side && walk_col + 1 < side) begin
                    walk_row++;
                    walk_col++;
                end else begin
                    walk_diag++;
                    load_diagonal(side);
                end
            end
            msog_pkg::MODE_ANTI: begin
                if (walk_row > 0 && walk_col + 1 < side) begin
                    walk_row--;
                    walk_col++;
                end else begin
                    walk_diag++;
                    load_diagonal(side);
                end
            end
            msog_pkg::MODE_SPIRAL_I: begin
                lo = walk_ring;
                hi = side - 1 - walk_ring;
                case (walk_leg)
                    msog_pkg::LEG_A: begin
                        if (walk_col < hi) walk_col++;
                        else if (hi - lo >= 2) begin
                            walk_leg = msog_pkg::LEG_B;
                            walk_row = lo + 1;
                            walk_col = hi;
                        end else begin
                            walk_leg = msog_pkg::LEG_C;
                            walk_row = hi;
                            walk_col = hi;
                        end
                    end
                    msog_pkg::LEG_B: begin
                        if (walk_row + 1 < hi) walk_row++;
                        else begin
                            walk_leg = msog_pkg::LEG_C;
                            walk_row = hi;
                            walk_col = hi;
                        end
                    end
                    msog_pkg::LEG_C: begin
                        if (walk_col > lo) walk_col--;
                        else if (hi - lo >= 2) begin
                            walk_leg = msog_pkg::LEG_D;
                            walk_row = hi - 1;
                            walk_col = lo;
                        end else begin
                            walk_ring++;
                            load_ring(h);
                        end
                    end
                    default: begin
                        if (walk_row > lo + 1) walk_row--;
                        else begin
                            walk_ring++;
                            load_ring(h);
                        end
                    end
                endcase
            end
            default: begin
                lo = h - 1 - walk_ring;
                hi = h + walk_ring;
                case (walk_leg)
                    msog_pkg::LEG_A: begin
                        if (walk_row + 1 < hi) walk_row++;
                        else begin
                            walk_leg = msog_pkg::LEG_B;
                            walk_row = hi;
                            walk_col = lo;
                        end
                    end
                    msog_pkg::LEG_B: begin
                        if (walk_col < hi) walk_col++;
                        else if (hi - lo >= 2) begin
                            walk_leg = msog_pkg::LEG_C;
                            walk_row = hi - 1;
                            walk_col = hi;
                        end else begin
                            walk_leg = msog_pkg::LEG_D;
                            walk_row = lo;
                            walk_col = hi;
                        end
                    end
                    msog_pkg::LEG_C: begin
                        if (walk_row > lo + 1) walk_row--;
                        else begin
                            walk_leg = msog_pkg::LEG_D;
                            walk_row = lo;
                            walk_col = hi;
                        end
                    end
                    default: begin
                        if (walk_col > lo) walk_col--;
                        else begin
                            walk_ring++;
                            load_ring(h);
                        end
                    end
                endcase
            end
        endcase
    endfunction

    function automatic t_scan_addr next_address(logic restart);
        int h;
        int total;
        t_scan_addr addr;
        h = effective_half();
        total = 4 * h * h;
        if (restart || !walk_live || walk_pos >= total - 1) rewind_walk(h);
        else begin
            advance_walk(h);
            walk_pos++;
        end
        walk_live = 1'b1;
        addr.row = msog_pkg::POS_W'(walk_row);
        addr.col = msog_pkg::POS_W'(walk_col);
        addr.seq = msog_pkg::SEQ_W'(walk_pos);
        addr.is_last = (walk_pos == total - 1);
        return addr;
    endfunction

    task automatic drain_addresses();
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        i_in_valid = 1'b0;
        while (addresses_due.size() != 0) @(posedge i_clk);
    endtask

    // any write also sends the walk back to its first cell
    task automatic write_register(input logic [msog_pkg::IDX_W-1:0] idx,
                                  input logic [msog_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        if (idx == msog_pkg::CFG_SCAN_MODE) cfg_mode = data[msog_pkg::MODE_W-1:0];
        else cfg_half = data[msog_pkg::HALF_W-1:0];
        walk_live = 1'b0;
    endtask

    task automatic send_beat(input logic restart, input logic typed,
                             input t_scan_addr typed_addr);
        int gap_pct;
        t_scan_addr addr;
        gap_pct = (idle_phase == 0) ? 28 : (idle_phase == 1) ? 88 : 0;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_restart = restart;
        do @(posedge i_clk); while (!o_in_ready);
        addr = next_address(restart);
        addresses_due.push_back(typed ? typed_addr : addr);
    endtask

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(0, 99) >= ((idle_phase == 0) ? 88 :
                                                 (idle_phase == 1) ? 28 : 0));
    end

    always @(posedge i_clk) begin
        t_scan_addr want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (addresses_due.size() == 0) begin
                $display("%0t: address beat with none due: row %0d col %0d seq %0d last %0b",
                         $realtime, o_row, o_col, o_seq_index, o_last);
                mismatches++;
            end else begin
                want = addresses_due.pop_front();
                if (o_row !== want.row || o_col !== want.col ||
                    o_seq_index !== want.seq || o_last !== want.is_last) begin
                    $display({"%0t: expected row %0d col %0d seq %0d last %0b, ",
                              "got row %0d col %0d seq %0d last %0b"},
                             $realtime, want.row, want.col, want.seq, want.is_last,
                             o_row, o_col, o_seq_index, o_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_plan_row plan [PLAN_LEN];
        int sent;
        int phase_no;
        int n;
        int sel;
        logic [msog_pkg::CFG_W-1:0] half_pick;

        // typed addresses: reset defaults, 2x2 corners and wrap, restart, largest sides
        plan = '{
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b1, {5'd0,  5'd19, 10'd0, 1'b0}},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b0, '0},
            '{1'b1, msog_pkg::CFG_HALF_SIDE, 5'd0,  1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b1, {5'd0,  5'd1,  10'd0, 1'b0}},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b1, {5'd1,  5'd0,  10'd3, 1'b1}},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b1, {5'd0,  5'd1,  10'd0, 1'b0}},
            '{1'b1, msog_pkg::CFG_SCAN_MODE, 5'd1,  1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b1, 1'b1, {5'd0,  5'd0,  10'd0, 1'b0}},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b1, 1'b1, {5'd0,  5'd0,  10'd0, 1'b0}},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b0, '0},
            '{1'b1, msog_pkg::CFG_SCAN_MODE, 5'd2,  1'b0, 1'b0, '0},
            '{1'b1, msog_pkg::CFG_HALF_SIDE, 5'd31, 1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b1, {5'd0,  5'd0,  10'd0, 1'b0}},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b1, 1'b1, {5'd0,  5'd0,  10'd0, 1'b0}},
            '{1'b1, msog_pkg::CFG_SCAN_MODE, 5'd3,  1'b0, 1'b0, '0},
            '{1'b1, msog_pkg::CFG_HALF_SIDE, 5'd1,  1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b1, {5'd1,  5'd0,  10'd0, 1'b0}},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b1, {5'd0,  5'd0,  10'd3, 1'b1}},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b0, '0},
            '{1'b1, msog_pkg::CFG_HALF_SIDE, 5'd16, 1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b1, {5'd16, 5'd15, 10'd0, 1'b0}},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b0, '0},
            '{1'b0, msog_pkg::CFG_SCAN_MODE, 5'd0,  1'b0, 1'b0, '0}
        };

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].is_cfg) begin
                drain_addresses();
                write_register(plan[i].idx, plan[i].data);
            end else begin
                send_beat(plan[i].restart, plan[i].typed, plan[i].addr);
            end
        end

        // random phases, mostly small sides so that the walk wraps often
        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_BEATS) begin
            drain_addresses();
            sel = $urandom_range(0, 9);
            if (sel < 7) half_pick = msog_pkg::CFG_W'($urandom_range(0, 4));
            else if (sel < 9) half_pick = msog_pkg::CFG_W'($urandom_range(5, 12));
            else half_pick = msog_pkg::CFG_W'($urandom_range(13, 31));
            sel = $urandom_range(0, 3);
            if (sel != 1) begin
                write_register(msog_pkg::CFG_SCAN_MODE, msog_pkg::CFG_W'($urandom_range(0, 31)));
            end
            if (sel != 0) write_register(msog_pkg::CFG_HALF_SIDE, half_pick);
            n = $urandom_range(16, 110);
            for (int i = 0; i < n && sent < RANDOM_BEATS; i++) begin
                // in the second phase the sender holds off mid-phase until the pipe is empty
                if (phase_no == 1 && i == n / 2) drain_addresses();
                send_beat($urandom_range(0, 99) < 2, 1'b0, '0);
                sent++;
                idle_phase = (sent * 3) / RANDOM_BEATS;
                if (idle_phase > 2) idle_phase = 2;
            end
            phase_no++;
        end

        drain_addresses();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> matrix_scan_order_generator.f
rtl/msog_pkg.sv
rtl/matrix_scan_order_generator.sv
sim/matrix_scan_order_generator_tb.sv
